// ===== rtl/gbs_pkg.sv =====
// Package for the greedy box suppression block: field widths, payload
// structs, per-cell control struct and codes. No dependencies.
package gbs_pkg;

   localparam int CoordW = 12;
   localparam int ScoreW = 16;
   localparam int ArrW   = 6;
   localparam int ThrW   = 16;
   localparam logic [ThrW-1:0] ThrReset = 16'd32768;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] top;
      logic [CoordW-1:0] width;
      logic [CoordW-1:0] height;
      logic [ScoreW-1:0] score;
      logic              final_box;
   } req_type;

   typedef struct packed {
      logic [CoordW-1:0] kept_left;
      logic [CoordW-1:0] kept_top;
      logic [CoordW-1:0] kept_width;
      logic [CoordW-1:0] kept_height;
      logic [ScoreW-1:0] kept_score;
      logic [ArrW-1:0]   arrival_index;
      logic              overflowed;
      logic              last_kept;
   } rsp_type;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] top;
      logic [CoordW-1:0] width;
      logic [CoordW-1:0] height;
      logic [ScoreW-1:0] score;
      logic [ArrW-1:0]   arrival;
   } box_type;

   typedef struct packed {
      logic    valid;
      logic    drop;
      box_type box;
   } slot_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2,
      OP_CLEAR  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type     op;
      box_type         new_box;
      box_type         kept_box;
      logic [ThrW-1:0] thr;
      logic            check_done;
   } cell_ctl_type;

endpackage

// ===== rtl/gbs_cell.sv =====
// One cell of the sorted box chain: holds one box, takes part in sorted
// insertion, shifts toward the head on pop, and tests itself against a kept box.
// Depends on gbs_pkg.
module gbs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gbs_pkg::cell_ctl_type ctl,
   input  gbs_pkg::slot_type     left_slot,
   input  logic                  left_cond,
   input  gbs_pkg::slot_type     right_slot,
   output gbs_pkg::slot_type     slot,
   output logic                  cond
);

   localparam int CW = gbs_pkg::CoordW;

   logic               valid_ff, valid_in;
   logic               drop_ff, drop_in;
   gbs_pkg::box_type   box_ff, box_in;

   logic [CW:0]        r1, r2, b1, b2, lo_x, hi_x, lo_y, hi_y;
   logic               hit1_in, hit1_ff, hit2_ff;
   logic [CW-1:0]      dx_ff, dy_ff;
   logic [2*CW-1:0]    area_ff, inter_ff;
   logic [gbs_pkg::ThrW+2*CW-1:0] tarea_ff;
   logic               over;

   assign cond = !valid_ff || (box_ff.score < ctl.new_box.score);
   assign slot = '{valid: valid_ff, drop: drop_ff, box: box_ff};

   // Overlap geometry of this box (under test) against the kept box.
   always_comb begin
      r1   = {1'b0, box_ff.left} + {1'b0, box_ff.width};
      b1   = {1'b0, box_ff.top} + {1'b0, box_ff.height};
      r2   = {1'b0, ctl.kept_box.left} + {1'b0, ctl.kept_box.width};
      b2   = {1'b0, ctl.kept_box.top} + {1'b0, ctl.kept_box.height};
      lo_x = (box_ff.left > ctl.kept_box.left) ? {1'b0, box_ff.left}
                                               : {1'b0, ctl.kept_box.left};
      lo_y = (box_ff.top > ctl.kept_box.top) ? {1'b0, box_ff.top}
                                             : {1'b0, ctl.kept_box.top};
      hi_x = (r1 < r2) ? r1 : r2;
      hi_y = (b1 < b2) ? b1 : b2;
      hit1_in = (hi_x > lo_x) && (hi_y > lo_y)
                && (box_ff.width != '0) && (box_ff.height != '0);
   end

   always_ff @(posedge clock) begin
      hit1_ff  <= hit1_in;
      dx_ff    <= CW'(hi_x - lo_x);
      dy_ff    <= CW'(hi_y - lo_y);
      area_ff  <= box_ff.width * box_ff.height;
      hit2_ff  <= hit1_ff;
      inter_ff <= dx_ff * dy_ff;
      tarea_ff <= ctl.thr * area_ff;
   end

   assign over = hit2_ff && ({inter_ff, 16'd0} > tarea_ff);

   always_comb begin
      valid_in = valid_ff;
      drop_in  = drop_ff;
      box_in   = box_ff;
      unique case (ctl.op)
         gbs_pkg::OP_INSERT: begin
            if (cond) begin
               if (left_cond) begin
                  valid_in = left_slot.valid;
                  drop_in  = left_slot.drop;
                  box_in   = left_slot.box;
               end else begin
                  valid_in = 1'b1;
                  drop_in  = 1'b0;
                  box_in   = ctl.new_box;
               end
            end
         end
         gbs_pkg::OP_POP: begin
            valid_in = right_slot.valid;
            drop_in  = right_slot.drop;
            box_in   = right_slot.box;
         end
         gbs_pkg::OP_CLEAR: begin
            valid_in = 1'b0;
            drop_in  = 1'b0;
         end
         gbs_pkg::OP_HOLD: begin
            if (ctl.check_done && valid_ff && over) begin
               drop_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         drop_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         drop_ff  <= drop_in;
      end
      box_ff <= box_in;
   end

endmodule

// ===== rtl/greedy_box_suppression.sv =====
// Top level of the greedy box suppression block: control sequencer, chain
// of gbs_cell instances, threshold register and result register.
// Depends on gbs_pkg and gbs_cell.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  gbs_pkg::req_type (one box)
//   rsp      out        rsp_valid/rsp_stall  gbs_pkg::rsp_type (one kept box)
//   csr      in         csr_valid/csr_ready  overlap threshold, 16 bits
//
// While loading, every box is inserted into the chain in its sorted place
// in the cycle it arrives. After the final box, the walk pops one box from
// the head per cycle while no kept box is being checked or emitted; each
// kept box goes through pop, the overlap test in every cell on the per-cell
// multiplier pipeline, and emit. Reset is synchronous and clears the chain
// valid bits, the counters and the threshold to one half. A stalled result
// holds the walk at the next emit, and boxes are not accepted while a batch
// is being walked.
module greedy_box_suppression #(
   parameter int MAX_BOXES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbs_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [gbs_pkg::ThrW-1:0] csr_data
);

   localparam int CntW = $clog2(MAX_BOXES + 1);

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_POP   = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CntW-1:0]           count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic [gbs_pkg::ThrW-1:0]  thr_ff;
   gbs_pkg::box_type          kept_ff, kept_in;
   logic [2:0]                chk_ff, chk_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   gbs_pkg::rsp_type          rsp_ff, rsp_in;

   gbs_pkg::cell_ctl_type     ctl;
   gbs_pkg::slot_type         slots [MAX_BOXES];
   logic [MAX_BOXES-1:0]      conds;
   logic [MAX_BOXES-1:0]      live;
   logic                      any_live;
   logic                      req_fire, full, emit_ok, last;
   gbs_pkg::box_type          new_box;

   // Threshold register always writable; users must write it only while idle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gbs_pkg::ThrReset;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign req_fire  = req_valid && !req_stall;
   assign full      = (count_ff == CntW'(MAX_BOXES));

   assign new_box = '{left: req_data.left, top: req_data.top,
                      width: req_data.width, height: req_data.height,
                      score: req_data.score, arrival: gbs_pkg::ArrW'(count_ff)};

   // A box is still a candidate when it sits in the chain and no kept box
   // has suppressed it yet.
   always_comb begin
      for (int i = 0; i < MAX_BOXES; i++) begin
         live[i] = slots[i].valid && !slots[i].drop;
      end
   end
   assign any_live = |live;

   assign emit_ok = !rsp_valid_ff || !rsp_stall;
   assign last    = !any_live;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      kept_in      = kept_ff;
      chk_in       = {chk_ff[1:0], 1'b0};
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.op         = gbs_pkg::OP_HOLD;
      ctl.new_box    = new_box;
      ctl.kept_box   = kept_ff;
      ctl.thr        = thr_ff;
      ctl.check_done = chk_ff[2];
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ctl.op   = gbs_pkg::OP_INSERT;
                  count_in = count_ff + 1'b1;
               end
               if (req_data.final_box) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            // The head leaves the chain every cycle; a surviving head is kept.
            ctl.op = gbs_pkg::OP_POP;
            if (slots[0].valid && !slots[0].drop) begin
               kept_in   = slots[0].box;
               chk_in[0] = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (chk_ff[2]) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kept_left: kept_ff.left, kept_top: kept_ff.top,
                          kept_width: kept_ff.width, kept_height: kept_ff.height,
                          kept_score: kept_ff.score, arrival_index: kept_ff.arrival,
                          overflowed: ovf_ff, last_kept: last};
               if (last) begin
                  ctl.op   = gbs_pkg::OP_CLEAR;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         chk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kept_ff <= kept_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The chain: slot 0 holds the highest score; equal scores keep arrival order.
   for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
      gbs_pkg::slot_type lslot, rslot;
      logic              lcond;
      if (g == 0) begin : g_head
         assign lslot = '0;
         assign lcond = 1'b0;
      end else begin : g_mid
         assign lslot = slots[g-1];
         assign lcond = conds[g-1];
      end
      if (g == MAX_BOXES - 1) begin : g_tail
         assign rslot = '0;
      end else begin : g_body
         assign rslot = slots[g+1];
      end
      gbs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_slot  (lslot),
         .left_cond  (lcond),
         .right_slot (rslot),
         .slot       (slots[g]),
         .cond       (conds[g])
      );
   end

   // The walk only pops while some candidate remains in the chain.
   a_pop_has_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> any_live)
      else $error("walk popping with no candidate left");

   // The overlap pipeline has drained before a kept box is emitted.
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (chk_ff == '0))
      else $error("emit while overlap test still in flight");

   // Count stays at capacity when a box arrives at a full chain.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire && full |=> (count_ff == CntW'(MAX_BOXES)) || (count_ff == '0))
      else $error("box count past capacity");

endmodule
